[src/ppsrs_pkg.sv]
package ppsrs_pkg;

    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED = 1'b1;

    // input function codes
    localparam logic [1:0] FUNC_FRAME  = 2'd0;
    localparam logic [1:0] FUNC_RD_WIN = 2'd1;
    localparam logic [1:0] FUNC_RD_TOT = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_COUNTED = 2'd0;
    localparam logic [1:0] KIND_IGNORED = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

endpackage

[src/per_peer_sequence_and_rtt_stats.sv]
// channel  direction  handshake                  payload
// input    in         i_valid / o_ready          i_func, i_peer, i_seq_num, i_echo_node,
//                                                i_echo_stamp, i_arrival_time
// result   out        o_valid / i_ready          o_kind .. o_drain_reached
// config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// the peer entry is read from the stats ram at accept, then modified and written back
// as the item leaves the compute state; no item is accepted before, so the next read sees it.
// reset clears a per-peer valid flag at once; an entry whose flag is clear reads as
// its reset value, so there is no clearing pass.
// a finished result waits in the output register; one more item may be accepted
// meanwhile and holds in the compute cycle until the output register frees.
module per_peer_sequence_and_rtt_stats #(
    parameter int PEER_COUNT   = 256,
    parameter int COUNTER_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_func,
    input  logic [7:0]                       i_peer,
    input  logic [15:0]                      i_seq_num,
    input  logic [7:0]                       i_echo_node,
    input  logic [31:0]                      i_echo_stamp,
    input  logic [31:0]                      i_arrival_time,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_kind,
    output logic                             o_peer_known,
    output logic [31:0]                      o_rx_count,
    output logic [31:0]                      o_lost_count,
    output logic [31:0]                      o_dup_count,
    output logic [31:0]                      o_reorder_count,
    output logic [31:0]                      o_rtt_count,
    output logic [31:0]                      o_rtt_min,
    output logic [31:0]                      o_rtt_max,
    output logic [63:0]                      o_rtt_sum,
    output logic                             o_drain_reached,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ppsrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);

    import ppsrs_pkg::*;

    localparam int AW = $clog2(PEER_COUNT);
    localparam int CB = COUNTER_BITS;
    localparam logic [8:0] PEER_LIMIT = 9'(PEER_COUNT);

    typedef struct packed {
        logic [63:0]   sum;
        logic [CB-1:0] count;
        logic [31:0]   min;
        logic [31:0]   max;
    } t_accum;

    typedef struct packed {
        logic          seen;
        logic [CB-1:0] rx;
        logic [CB-1:0] lost;
        logic [CB-1:0] dup;
        logic [CB-1:0] reorder;
        logic          seq_valid;
        logic [15:0]   prev_seq;
        t_accum        win;
        t_accum        tot;
    } t_entry;

    localparam int EW = $bits(t_entry);
    localparam t_accum ACC_RESET = '{sum: '0, count: '0, min: '1, max: '0};

    typedef enum logic {S_IDLE, S_CALC} t_state;

    t_state r_state;

    // configuration
    logic [7:0]  r_own;
    logic [31:0] r_expected;

    // drain tracking: counts only grow, so the largest one stands for the whole table
    logic [CB-1:0] r_max_rx;
    logic          r_drain;

    logic [(1<<AW)-1:0] r_valid;
    logic               r_rd_valid;

    // captured item
    logic [1:0]  r_func;
    logic [7:0]  r_peer;
    logic [15:0] r_seq;
    logic        r_echo;
    logic [31:0] r_stamp;
    logic [31:0] r_arrival;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic        r_peer_known;
    logic [31:0] r_rx_count;
    logic [31:0] r_lost_count;
    logic [31:0] r_dup_count;
    logic [31:0] r_reorder_count;
    logic [31:0] r_rtt_count;
    logic [31:0] r_rtt_min;
    logic [31:0] r_rtt_max;
    logic [63:0] r_rtt_sum;
    logic        r_drain_reached;

    logic [EW-1:0] ram_rdata;
    t_entry        rd_entry;
    t_entry        n_entry;
    t_accum        sel_acc;
    logic          n_we;
    logic          ram_we;
    logic          n_counted;
    logic          n_drain;
    logic [CB-1:0] n_max_rx;
    logic          out_free;
    logic          in_accept;
    logic          peer_ok;
    logic [15:0]   next_seq;
    logic [15:0]   gap;
    logic [31:0]   rtt;
    logic [CB:0]   lost_sum;

    logic [1:0]  n_kind;
    logic        n_peer_known;
    logic [31:0] n_rx_count;
    logic [31:0] n_lost_count;
    logic [31:0] n_dup_count;
    logic [31:0] n_reorder_count;
    logic [31:0] n_rtt_count;
    logic [31:0] n_rtt_min;
    logic [31:0] n_rtt_max;
    logic [63:0] n_rtt_sum;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == '1) ? v : v + CB'(1);
    endfunction

    function automatic t_accum acc_add(input t_accum a, input logic [31:0] v);
        t_accum     r;
        logic [64:0] s;
        s       = {1'b0, a.sum} + 65'(v);
        r.sum   = s[64] ? '1 : s[63:0];
        r.count = sat_inc(a.count);
        r.max   = (v > a.max) ? v : a.max;
        r.min   = (v < a.min) ? v : a.min;
        return r;
    endfunction

    function automatic logic [31:0] to32(input logic [CB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign peer_ok     = ({1'b0, r_peer} < PEER_LIMIT);
    // write back only in the cycle the item leaves the compute stage
    assign ram_we      = n_we && (r_state == S_CALC) && out_free;

    ppsrs_ram #(
        .WIDTH (EW),
        .DEPTH (PEER_COUNT)
    ) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_peer[AW-1:0]),
        .i_wdata (n_entry),
        .i_re    (in_accept),
        .i_raddr (i_peer[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_rd_valid) begin
            rd_entry = t_entry'(ram_rdata);
        end else begin
            rd_entry     = '0;
            rd_entry.win = ACC_RESET;
            rd_entry.tot = ACC_RESET;
        end
    end

    always_comb begin
        n_entry   = rd_entry;
        n_we      = 1'b0;
        n_counted = 1'b0;
        n_drain   = r_drain;
        n_max_rx  = r_max_rx;
        next_seq  = rd_entry.prev_seq + 16'd1;
        gap       = r_seq - next_seq;
        rtt       = r_arrival - r_stamp;
        lost_sum  = {1'b0, rd_entry.lost} + (CB + 1)'(gap);
        sel_acc   = rd_entry.tot;

        unique case (r_func) inside
            FUNC_RD_WIN, FUNC_RD_TOT: begin
                if (r_func == FUNC_RD_WIN) begin
                    sel_acc     = rd_entry.win;
                    n_entry.win = ACC_RESET;
                    n_we        = peer_ok;
                end
            end
            FUNC_FRAME: begin
                if (peer_ok && r_peer != 8'd0 && r_peer != r_own) begin
                    n_counted = 1'b1;
                    n_we      = 1'b1;
                    n_entry.seen = 1'b1;
                    n_entry.rx   = sat_inc(rd_entry.rx);
                    if (rd_entry.seq_valid) begin
                        if (r_seq == rd_entry.prev_seq) begin
                            n_entry.dup = sat_inc(rd_entry.dup);
                        end else if (r_seq != next_seq) begin
                            // forward gap below half the sequence space counts as loss
                            if (!gap[15]) begin
                                n_entry.lost = lost_sum[CB] ? '1 : lost_sum[CB-1:0];
                            end else begin
                                n_entry.reorder = sat_inc(rd_entry.reorder);
                            end
                        end
                    end
                    n_entry.seq_valid = 1'b1;
                    n_entry.prev_seq  = r_seq;
                    if (r_echo) begin
                        n_entry.win = acc_add(rd_entry.win, rtt);
                        n_entry.tot = acc_add(rd_entry.tot, rtt);
                    end
                    if (n_entry.rx > r_max_rx) begin
                        n_max_rx = n_entry.rx;
                    end
                    if (r_expected != 32'd0 && 64'(n_max_rx) >= 64'(r_expected)) begin
                        n_drain = 1'b1;
                    end
                    sel_acc = n_entry.tot;
                end
            end
            default: begin
                n_counted = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_peer_known    = 1'b0;
        n_rx_count      = 32'd0;
        n_lost_count    = 32'd0;
        n_dup_count     = 32'd0;
        n_reorder_count = 32'd0;
        n_rtt_count     = 32'd0;
        n_rtt_min       = 32'd0;
        n_rtt_max       = 32'd0;
        n_rtt_sum       = 64'd0;
        if (r_func == FUNC_RD_WIN || r_func == FUNC_RD_TOT) begin
            n_kind = KIND_READ;
        end else if (n_counted) begin
            n_kind = KIND_COUNTED;
        end else begin
            n_kind = KIND_IGNORED;
        end
        if (n_counted || ((r_func == FUNC_RD_WIN || r_func == FUNC_RD_TOT) && peer_ok)) begin
            n_peer_known    = n_entry.seen;
            n_rx_count      = to32(n_entry.rx);
            n_lost_count    = to32(n_entry.lost);
            n_dup_count     = to32(n_entry.dup);
            n_reorder_count = to32(n_entry.reorder);
            n_rtt_count     = to32(sel_acc.count);
            n_rtt_sum       = sel_acc.sum;
            if (sel_acc.count != '0) begin
                n_rtt_min = sel_acc.min;
                n_rtt_max = sel_acc.max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func    <= i_func;
            r_peer    <= i_peer;
            r_seq     <= i_seq_num;
            r_echo    <= (i_echo_node == r_own);
            r_stamp   <= i_echo_stamp;
            r_arrival <= i_arrival_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_own       <= 8'd1;
            r_expected  <= 32'd0;
            r_max_rx    <= '0;
            r_drain     <= 1'b0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OWN_NODE: r_own      <= i_cfg_data[7:0];
                    CFG_EXPECTED: r_expected <= i_cfg_data;
                    default:      r_own      <= r_own;
                endcase
            end
            if (r_state == S_CALC && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_rd_valid <= r_valid[i_peer[AW-1:0]];
                        r_state    <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (n_we) begin
                            r_valid[r_peer[AW-1:0]] <= 1'b1;
                        end
                        r_max_rx <= n_max_rx;
                        r_drain  <= n_drain;

                        r_drain_reached <= n_drain;
                        r_kind          <= n_kind;
                        r_peer_known    <= n_peer_known;
                        r_rx_count      <= n_rx_count;
                        r_lost_count    <= n_lost_count;
                        r_dup_count     <= n_dup_count;
                        r_reorder_count <= n_reorder_count;
                        r_rtt_count     <= n_rtt_count;
                        r_rtt_min       <= n_rtt_min;
                        r_rtt_max       <= n_rtt_max;
                        r_rtt_sum       <= n_rtt_sum;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_peer_known    = r_peer_known;
    assign o_rx_count      = r_rx_count;
    assign o_lost_count    = r_lost_count;
    assign o_dup_count     = r_dup_count;
    assign o_reorder_count = r_reorder_count;
    assign o_rtt_count     = r_rtt_count;
    assign o_rtt_min       = r_rtt_min;
    assign o_rtt_max       = r_rtt_max;
    assign o_rtt_sum       = r_rtt_sum;
    assign o_drain_reached = r_drain_reached;

endmodule

[src/ppsrs_ram.sv]
module ppsrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
